/* rtl/core/ffwm_pkg.sv */
// ---------------------------------------------------------------------------
// ffwm_pkg: shared types and constants of the flow window monitor
// Operation codes, register indexes, configuration bundle, FSM state and the
// command/status groups between controller and datapath.
// ---------------------------------------------------------------------------
package ffwm_pkg;

  typedef enum logic {
    OP_ADD     = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  localparam logic [1:0] CFG_BUCKET_SIZE = 2'd0;
  localparam logic [1:0] CFG_MIN_CHECK   = 2'd1;
  localparam logic [1:0] CFG_ERR_FACTOR  = 2'd2;
  localparam logic [1:0] CFG_STEPS_COUNT = 2'd3;

  localparam logic [15:0] RST_BUCKET_SIZE = 16'd1000;
  localparam logic [19:0] RST_MIN_CHECK   = 20'd5000;
  localparam logic [15:0] RST_ERR_FACTOR  = 16'd52429;
  localparam logic [31:0] RST_STEPS_COUNT = 32'd166930;

  typedef struct packed {
    logic [15:0] bucket_size_steps;
    logic [19:0] min_check_steps;
    logic [15:0] error_factor_q16;
    logic [31:0] steps_per_count_q16;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_SUM,
    ST_DRAIN,
    ST_MUL,
    ST_LHS,
    ST_EVAL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;      // latch the accepted item
    logic restart;   // clear the sensor's ring
    logic rd_cur;    // read the sensor's current bucket
    logic wr_plain;  // add sample onto the current bucket
    logic advance;   // close bucket, step ring, start window sum
    logic sum_rd;    // read next bucket of the window walk
    logic mul;       // register the two products
    logic lhs;       // register the step-side term
    logic eval;      // decide flow error, store sample
    logic out_load;  // load the result register
  } cmd_t;

  typedef struct packed {
    logic drop;      // item gives no result
    logic restart;   // item is a restart
    logic close;     // current bucket is full
    logic cnt_last;  // last bucket read issued
    logic out_free;  // result register can take a new item
  } sts_t;

endpackage

/* rtl/core/filament_flow_window_monitor.sv */
// ---------------------------------------------------------------------------
// filament_flow_window_monitor: filament flow window monitor, top level
// Configuration registers, controller and datapath.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   operation, sensor, angle,
//                                                 angle_valid, step_position
//   out      output     out_valid_o / out_stall_i checked, flow_error,
//                                                 sensor_out, angle_total,
//                                                 steps_total, bucket_index
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// One item at a time. Accept to result: a restart passes decode and output;
// a sample that does not close a bucket passes decode, read and output; a
// closing sample also walks the window, one bucket read per cycle through the
// single memory port, then drain, mul, lhs and eval. The next item is taken in
// the cycle after the result is loaded. Dropped items (invalid sample) leave
// from decode. Reset clears every ring at once via per-bucket valid bits.
// The result sits in an output register; a new item is taken while it waits.
// ---------------------------------------------------------------------------
module filament_flow_window_monitor #(
  parameter int SENSORS      = 4,
  parameter int BUCKETS      = 8,
  parameter int ANGLE_COUNTS = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [1:0]         sensor_i,
  input  logic [11:0]        angle_i,
  input  logic               angle_valid_i,
  input  logic signed [31:0] step_position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               checked_o,
  output logic               flow_error_o,
  output logic [1:0]         sensor_out_o,
  output logic signed [31:0] angle_total_o,
  output logic signed [31:0] steps_total_o,
  output logic [2:0]         bucket_index_o
);

  ffwm_pkg::cfg_t cfg_q;
  ffwm_pkg::cmd_t cmd;
  ffwm_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bucket_size_steps   <= ffwm_pkg::RST_BUCKET_SIZE;
      cfg_q.min_check_steps     <= ffwm_pkg::RST_MIN_CHECK;
      cfg_q.error_factor_q16    <= ffwm_pkg::RST_ERR_FACTOR;
      cfg_q.steps_per_count_q16 <= ffwm_pkg::RST_STEPS_COUNT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ffwm_pkg::CFG_BUCKET_SIZE: cfg_q.bucket_size_steps   <= cfg_data_i[15:0];
        ffwm_pkg::CFG_MIN_CHECK:   cfg_q.min_check_steps     <= cfg_data_i[19:0];
        ffwm_pkg::CFG_ERR_FACTOR:  cfg_q.error_factor_q16    <= cfg_data_i[15:0];
        ffwm_pkg::CFG_STEPS_COUNT: cfg_q.steps_per_count_q16 <= cfg_data_i;
      endcase
    end
  end

  ffwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffwm_datapath #(
    .SENSORS      (SENSORS),
    .BUCKETS      (BUCKETS),
    .ANGLE_COUNTS (ANGLE_COUNTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .sensor_i        (sensor_i),
    .angle_i         (angle_i),
    .angle_valid_i   (angle_valid_i),
    .step_position_i (step_position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .checked_o       (checked_o),
    .flow_error_o    (flow_error_o),
    .sensor_out_o    (sensor_out_o),
    .angle_total_o   (angle_total_o),
    .steps_total_o   (steps_total_o),
    .bucket_index_o  (bucket_index_o)
  );

endmodule

/* rtl/core/ffwm_ctrl.sv */
// ---------------------------------------------------------------------------
// ffwm_ctrl: sequencing of one item
// Walks decode, bucket read, window sum, flow check and result hand-off.
// ---------------------------------------------------------------------------
module ffwm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ffwm_pkg::sts_t sts_i,
  output ffwm_pkg::cmd_t cmd_o
);

  ffwm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffwm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ffwm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ffwm_pkg::ST_DECODE;
        end
      end
      ffwm_pkg::ST_DECODE: begin
        priority if (sts_i.drop) begin
          state_d = ffwm_pkg::ST_IDLE;
        end else if (sts_i.restart) begin
          cmd_o.restart = 1'b1;
          state_d       = ffwm_pkg::ST_OUT;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d      = ffwm_pkg::ST_READ;
        end
      end
      ffwm_pkg::ST_READ: begin
        if (sts_i.close) begin
          cmd_o.advance = 1'b1;
          state_d       = ffwm_pkg::ST_SUM;
        end else begin
          cmd_o.wr_plain = 1'b1;
          state_d        = ffwm_pkg::ST_OUT;
        end
      end
      ffwm_pkg::ST_SUM: begin
        cmd_o.sum_rd = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ffwm_pkg::ST_DRAIN;
        end
      end
      ffwm_pkg::ST_DRAIN: state_d = ffwm_pkg::ST_MUL;
      ffwm_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ffwm_pkg::ST_LHS;
      end
      ffwm_pkg::ST_LHS: begin
        cmd_o.lhs = 1'b1;
        state_d   = ffwm_pkg::ST_EVAL;
      end
      ffwm_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = ffwm_pkg::ST_OUT;
      end
      ffwm_pkg::ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ffwm_pkg::ST_IDLE;
        end
      end
      default: state_d = ffwm_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ffwm_pkg::ST_IDLE);

endmodule

/* rtl/core/ffwm_datapath.sv */
// ---------------------------------------------------------------------------
// ffwm_datapath: bucket store, window sum and flow check
// Holds the per-sensor rings in a one-read one-write memory with a valid
// bit per bucket, the sensor state, the check arithmetic and the result
// register.
// ---------------------------------------------------------------------------
module ffwm_datapath #(
  parameter int SENSORS      = 4,
  parameter int BUCKETS      = 8,
  parameter int ANGLE_COUNTS = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ffwm_pkg::cfg_t     cfg_i,
  input  ffwm_pkg::cmd_t     cmd_i,
  output ffwm_pkg::sts_t     sts_o,
  input  logic               operation_i,
  input  logic [1:0]         sensor_i,
  input  logic [11:0]        angle_i,
  input  logic               angle_valid_i,
  input  logic signed [31:0] step_position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               checked_o,
  output logic               flow_error_o,
  output logic [1:0]         sensor_out_o,
  output logic signed [31:0] angle_total_o,
  output logic signed [31:0] steps_total_o,
  output logic [2:0]         bucket_index_o
);

  localparam int SIW     = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int BIW     = $clog2(BUCKETS);
  localparam int DEPTH   = SENSORS * BUCKETS;
  localparam int MW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ANG_LOG = $clog2(ANGLE_COUNTS);
  localparam int ANG_DW  = ((ANG_LOG > 12) ? ANG_LOG : 12) + 2;

  localparam logic [BIW-1:0]           LAST_B   = BIW'(BUCKETS - 1);
  localparam logic signed [ANG_DW-1:0] ANG_FULL = ANG_DW'(ANGLE_COUNTS);
  localparam logic signed [ANG_DW-1:0] ANG_HALF = ANG_DW'(ANGLE_COUNTS / 2);
  localparam logic signed [ANG_DW-1:0] ANG_NEG  = ANG_DW'(-(ANGLE_COUNTS / 2));

  // item
  logic               op_q;
  logic [1:0]         sensor_q;
  logic [11:0]        angle_q;
  logic               avalid_q;
  logic signed [31:0] pos_q;

  // per-sensor state
  logic [11:0]    last_angle_q [SENSORS];
  logic [BIW-1:0] ring_q       [SENSORS];
  logic [31:0]    prev_steps_q;

  // bucket store: {angle sum, step sum}
  logic [63:0]                    mem [DEPTH];
  logic [SENSORS-1:0][BUCKETS-1:0] vld_q;
  logic [63:0]                    rdata_q;
  logic                           rvld_q;
  logic                           acc_pend_q;

  logic [BIW-1:0] cur_q, cnt_q;
  logic [31:0]    atot_q, stot_q;
  logic [47:0]    magef_q;
  logic signed [63:0] prod_q;
  logic signed [49:0] lhs_q;

  logic [SIW-1:0]     sidx;
  logic [BIW-1:0]     rd_b, nxt_b, wr_b;
  logic [MW-1:0]      rd_addr, wr_addr;
  logic [63:0]        rmask;
  logic signed [ANG_DW-1:0] dang_raw, dang;
  logic [31:0]        dang32, dstep, base_a, base_s;
  logic               do_wr, flow_err;
  logic [31:0]        mag;
  logic signed [32:0] av33, spc33;
  logic signed [65:0] prod_full;

  assign sidx  = SIW'(sensor_q);
  assign rmask = rvld_q ? rdata_q : 64'h0;

  assign sts_o.drop     = (int'(sensor_q) >= SENSORS) ||
                          ((op_q == ffwm_pkg::OP_ADD) && !avalid_q);
  assign sts_o.restart  = (op_q == ffwm_pkg::OP_RESTART);
  assign sts_o.close    = $signed(rmask[31:0]) >= $signed({16'h0, cfg_i.bucket_size_steps});
  assign sts_o.cnt_last = (cnt_q == LAST_B);
  assign sts_o.out_free = !out_valid_o || !out_stall_i;

  assign rd_b    = cmd_i.rd_cur ? ring_q[sidx] : cnt_q;
  assign rd_addr = MW'(int'(sidx) * BUCKETS + int'(rd_b));
  assign nxt_b   = (cur_q == LAST_B) ? '0 : cur_q + 1'b1;

  // wrapped angle change, half-turn rule
  always_comb begin
    dang_raw = $signed(ANG_DW'(angle_q)) - $signed(ANG_DW'(last_angle_q[sidx]));
    if (dang_raw > ANG_HALF) begin
      dang = dang_raw - ANG_FULL;
    end else if (dang_raw < ANG_NEG) begin
      dang = dang_raw + ANG_FULL;
    end else begin
      dang = dang_raw;
    end
  end
  assign dang32 = 32'(dang);
  assign dstep  = pos_q - prev_steps_q;

  // flow check
  assign mag       = stot_q[31] ? (32'h0 - stot_q) : stot_q;
  assign av33      = {atot_q[31], atot_q};
  assign spc33     = {1'b0, cfg_i.steps_per_count_q16};
  assign prod_full = 66'(av33) * 66'(spc33);
  assign flow_err  = ($signed(stot_q) >= $signed({12'h0, cfg_i.min_check_steps})) &&
                     ($signed({{14{lhs_q[49]}}, lhs_q}) > prod_q);

  // sample write: on a closed bucket the target is freshly cleared
  assign do_wr   = cmd_i.wr_plain || cmd_i.eval;
  assign wr_b    = (cmd_i.eval && flow_err) ? '0 : cur_q;
  assign wr_addr = MW'(int'(sidx) * BUCKETS + int'(wr_b));
  assign base_a  = cmd_i.wr_plain ? rmask[63:32] : 32'h0;
  assign base_s  = cmd_i.wr_plain ? rmask[31:0] : 32'h0;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_addr] <= {base_a + dang32, base_s + dstep};
    end
    if (cmd_i.rd_cur || cmd_i.sum_rd) begin
      rdata_q <= mem[rd_addr];
      rvld_q  <= vld_q[sidx][rd_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= operation_i;
      sensor_q <= sensor_i;
      angle_q  <= angle_i;
      avalid_q <= angle_valid_i;
      pos_q    <= step_position_i;
    end
    if (cmd_i.mul) begin
      magef_q <= 48'(mag) * 48'(cfg_i.error_factor_q16);
      prod_q  <= prod_full[63:0];
    end
    if (cmd_i.lhs) begin
      lhs_q <= $signed({{2{stot_q[31]}}, stot_q, 16'h0}) - $signed({2'b0, magef_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SENSORS; s++) begin
        last_angle_q[s] <= '0;
        ring_q[s]       <= '0;
      end
      prev_steps_q <= '0;
      vld_q        <= '0;
      acc_pend_q   <= 1'b0;
      cur_q        <= '0;
      cnt_q        <= '0;
      atot_q       <= '0;
      stot_q       <= '0;
      out_valid_o  <= 1'b0;
    end else begin
      acc_pend_q <= cmd_i.sum_rd;
      if (cmd_i.load) begin
        atot_q <= '0;
        stot_q <= '0;
      end
      if (cmd_i.restart) begin
        vld_q[sidx]  <= '0;
        ring_q[sidx] <= '0;
        cur_q        <= '0;
        prev_steps_q <= pos_q;
        if (avalid_q) begin
          last_angle_q[sidx] <= angle_q;
        end
      end
      if (cmd_i.rd_cur) begin
        cur_q <= ring_q[sidx];
      end
      if (cmd_i.advance) begin
        cur_q              <= nxt_b;
        ring_q[sidx]       <= nxt_b;
        vld_q[sidx][nxt_b] <= 1'b0;
        cnt_q              <= '0;
      end
      if (cmd_i.sum_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (acc_pend_q) begin
        atot_q <= atot_q + rmask[63:32];
        stot_q <= stot_q + rmask[31:0];
      end
      if (cmd_i.eval && flow_err) begin
        // ring starts again with the sample alone in bucket 0
        vld_q[sidx]  <= BUCKETS'(1);
        ring_q[sidx] <= '0;
        cur_q        <= '0;
      end else if (do_wr) begin
        vld_q[sidx][wr_b] <= 1'b1;
      end
      if (do_wr) begin
        last_angle_q[sidx] <= angle_q;
        prev_steps_q       <= pos_q;
      end
      if (cmd_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // result register
  logic chk_q, err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q <= 1'b0;
      err_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        chk_q <= 1'b0;
        err_q <= 1'b0;
      end
      if (cmd_i.eval) begin
        chk_q <= 1'b1;
        err_q <= flow_err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      checked_o      <= chk_q;
      flow_error_o   <= err_q;
      sensor_out_o   <= sensor_q;
      angle_total_o  <= atot_q;
      steps_total_o  <= stot_q;
      bucket_index_o <= 3'(cur_q);
    end
  end

endmodule
